// File: design/b62enc_pkg.sv
package b62enc_pkg;

   // field widths
   localparam int VALUE_W    = 64;
   localparam int CHAR_W     = 8;
   localparam int CAP_W      = 8;
   localparam int DIGIT_W    = 6;
   localparam int BYTE_W     = 8;
   localparam int CNT_W      = 4;
   localparam int STEP_CNT_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // radix and digit limits
   localparam int RADIX           = 62;
   localparam int MAX_DIGITS      = 11;
   localparam int STEPS_PER_DIGIT = VALUE_W / BYTE_W;

   // register map
   localparam logic [CAP_W-1:0] CAP_RESET        = 8'd13;
   localparam logic             REG_OUT_CAPACITY = 1'b0;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_FAIL  = 8'h00;

   // classified request handed from front to back
   typedef struct packed {
      logic               neg;
      logic               zero;
      logic               cap_fail;
      logic [VALUE_W-1:0] mag;
   } entry_type;

   // digit value 0..61 to its character: 0-9, a-z, A-Z
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      logic [CHAR_W-1:0] ch;
      dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (dx < 8'd10) begin
         ch = CHAR_ZERO + dx;
      end else if (dx < 8'd36) begin
         ch = CHAR_LOWER + dx - 8'd10;
      end else begin
         ch = CHAR_UPPER + dx - 8'd36;
      end
      return ch;
   endfunction

endpackage

// File: design/b62enc_front.sv
module b62enc_front (
   input  logic [b62enc_pkg::CAP_W-1:0]   cap,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [b62enc_pkg::VALUE_W-1:0] req_value,
   input  logic                           q_full,
   output logic                           q_push,
   output b62enc_pkg::entry_type          q_data
);

   logic [b62enc_pkg::VALUE_W-1:0] bits;

   assign bits = req_value;

   // take a request whenever the queue has room
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // sign, magnitude (most negative value wraps to 2^63) and short cases
   always_comb begin
      q_data.neg      = bits[b62enc_pkg::VALUE_W-1];
      q_data.mag      = bits[b62enc_pkg::VALUE_W-1] ? (~bits + 64'd1) : bits;
      q_data.zero     = (bits == '0);
      q_data.cap_fail = (cap < 8'd2);
   end

endmodule

// File: design/b62enc_queue.sv
module b62enc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b62enc_pkg::entry_type push_data,
   output logic                  full,
   input  logic                  pop,
   output b62enc_pkg::entry_type pop_data,
   output logic                  empty
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   b62enc_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff,  count_in;

   assign full     = (count_ff == COUNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/b62enc_back.sv
module b62enc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [b62enc_pkg::CAP_W-1:0]      cap,
   input  logic                              q_empty,
   output logic                              q_pop,
   input  b62enc_pkg::entry_type             q_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [b62enc_pkg::CHAR_W-1:0]     rsp_char_code,
   output logic                              rsp_last,
   output logic                              rsp_ok
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_SIGN,
      ST_DIGITS,
      ST_SINGLE
   } state_type;

   state_type state_ff, state_in;

   logic [b62enc_pkg::VALUE_W-1:0]    div_ff, div_in;
   logic [b62enc_pkg::DIGIT_W-1:0]    rem_ff, rem_in;
   logic [b62enc_pkg::STEP_CNT_W-1:0] step_ff, step_in;
   logic [b62enc_pkg::CNT_W-1:0]      ndig_ff, ndig_in;
   logic [b62enc_pkg::CNT_W-1:0]      idx_ff, idx_in;
   logic                              neg_ff, neg_in;
   logic [b62enc_pkg::CHAR_W-1:0]     single_char_ff, single_char_in;
   logic                              single_ok_ff, single_ok_in;
   logic [b62enc_pkg::DIGIT_W-1:0]    digits_ff [b62enc_pkg::MAX_DIGITS];

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [b62enc_pkg::CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              rsp_ok_ff, rsp_ok_in;

   logic                              out_free;
   logic                              digit_we;
   logic [b62enc_pkg::BYTE_W-1:0]     q_byte;
   logic [b62enc_pkg::DIGIT_W-1:0]    rem_step;
   logic [b62enc_pkg::VALUE_W-1:0]    quo;
   logic [b62enc_pkg::CNT_W:0]        needed;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_ok        = rsp_ok_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // one byte of long division by the radix: eight compare-subtract steps
   always_comb begin
      logic [b62enc_pkg::DIGIT_W:0]   t;
      logic [b62enc_pkg::DIGIT_W-1:0] r;
      r      = rem_ff;
      q_byte = '0;
      for (int b = b62enc_pkg::BYTE_W - 1; b >= 0; b--) begin
         t = {r, div_ff[b62enc_pkg::VALUE_W - b62enc_pkg::BYTE_W + b]};
         if (t >= 7'(b62enc_pkg::RADIX)) begin
            q_byte[b] = 1'b1;
            r         = 6'(t - 7'(b62enc_pkg::RADIX));
         end else begin
            r = t[b62enc_pkg::DIGIT_W-1:0];
         end
      end
      rem_step = r;
      quo      = {div_ff[b62enc_pkg::VALUE_W-b62enc_pkg::BYTE_W-1:0], q_byte};
   end

   // sign + digits + terminator
   assign needed = {1'b0, ndig_ff} + {4'b0, neg_ff} + 5'd1;

   // sequencer and output register
   always_comb begin
      state_in       = state_ff;
      div_in         = div_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      ndig_in        = ndig_ff;
      idx_in         = idx_ff;
      neg_in         = neg_ff;
      single_char_in = single_char_ff;
      single_ok_in   = single_ok_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_ok_in      = rsp_ok_ff;
      q_pop          = 1'b0;
      digit_we       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               neg_in  = q_data.neg;
               div_in  = q_data.mag;
               rem_in  = '0;
               step_in = '0;
               ndig_in = '0;
               if (q_data.cap_fail) begin
                  single_char_in = b62enc_pkg::CHAR_FAIL;
                  single_ok_in   = 1'b0;
                  state_in       = ST_SINGLE;
               end else if (q_data.zero) begin
                  single_char_in = b62enc_pkg::CHAR_ZERO;
                  single_ok_in   = 1'b1;
                  state_in       = ST_SINGLE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            div_in  = quo;
            rem_in  = rem_step;
            step_in = step_ff + 1'b1;
            if (step_ff == 3'(b62enc_pkg::STEPS_PER_DIGIT - 1)) begin
               // digit complete: remainder is the next digit, least significant first
               digit_we = 1'b1;
               ndig_in  = ndig_ff + 1'b1;
               rem_in   = '0;
               if (quo == '0) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            idx_in = ndig_ff - 1'b1;
            if ({3'b0, needed} > cap) begin
               single_char_in = b62enc_pkg::CHAR_FAIL;
               single_ok_in   = 1'b0;
               state_in       = ST_SINGLE;
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = b62enc_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_ok_in    = 1'b1;
               state_in     = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = b62enc_pkg::digit_char(digits_ff[idx_ff]);
               rsp_last_in  = (idx_ff == '0);
               rsp_ok_in    = 1'b1;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = single_char_ff;
               rsp_last_in  = 1'b1;
               rsp_ok_in    = single_ok_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      div_ff         <= div_in;
      rem_ff         <= rem_in;
      step_ff        <= step_in;
      ndig_ff        <= ndig_in;
      idx_ff         <= idx_in;
      neg_ff         <= neg_in;
      single_char_ff <= single_char_in;
      single_ok_ff   <= single_ok_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_ok_ff      <= rsp_ok_in;
      if (digit_we) begin
         digits_ff[ndig_ff] <= rem_step;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a failure result always closes its request
   a_fail_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_last_ff)
      else $error("failure result without last");

   // digit count stays within the widest encoding
   a_ndig_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE && state_ff != ST_SINGLE |->
         ndig_ff <= 4'(b62enc_pkg::MAX_DIGITS))
      else $error("digit count overflow");

   // emission only starts with at least one digit stored
   a_digits_present: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIGN || state_ff == ST_DIGITS |-> ndig_ff != '0)
      else $error("emission with no digits");

   // loading the final digit returns the sequencer to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGITS && out_free && idx_ff == '0 |=>
         state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff)
      else $error("final digit did not end the request");

endmodule

// File: design/base62_signed_encoder.sv
// Flow: a request is pushed into the queue and dequeued by the sequencer; each base-62 digit
// takes a full pass of long division (one byte of the 64-bit magnitude per cycle through the
// long-division unit), then a capacity check, then one character per cycle while not stalled.
// The sequencer takes no new request until the last character of the one before is out, and
// the division unit bounds that; a 2-deep queue decouples intake from the sequencer.
// Reset (synchronous, active high) empties the queue and output, sets out_capacity to 13.
module base62_signed_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [b62enc_pkg::VALUE_W-1:0]  req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [b62enc_pkg::CHAR_W-1:0]          rsp_char_code,
   output logic                                   rsp_last,
   output logic                                   rsp_ok,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [b62enc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [b62enc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [b62enc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                   csr_pready
);

   logic [b62enc_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic                         reg_sel;
   logic                         q_full;
   logic                         q_empty;
   logic                         q_push;
   logic                         q_pop;
   b62enc_pkg::entry_type        q_wdata;
   b62enc_pkg::entry_type        q_rdata;

   // register file: out_capacity only
   assign reg_sel    = (csr_paddr[b62enc_pkg::CSR_ADDR_W-1] == b62enc_pkg::REG_OUT_CAPACITY);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? {{(b62enc_pkg::CSR_DATA_W-b62enc_pkg::CAP_W){1'b0}}, cap_ff}
                               : '0;

   always_comb begin
      cap_in = cap_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         cap_in = csr_pwdata[b62enc_pkg::CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= b62enc_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // intake and classification
   b62enc_front u_front (
      .cap       (cap_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   b62enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   // digit conversion and character output
   b62enc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cap           (cap_ff),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .q_data        (q_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .rsp_ok        (rsp_ok)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

// One character of expected encoder output
typedef struct packed {
   logic [7:0] code;
   logic       last;
   logic       ok;
} text_char_type;

// Predicts the base-62 text of each accepted request and checks emitted characters
class encoding_scoreboard;
   logic [7:0]     capacity;
   text_char_type  pending_chars[$];
   int             errors;
   string          alphabet;

   function new();
      capacity = b62enc_pkg::CAP_RESET;
      errors   = 0;
      alphabet = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   endfunction

   function int pending_count();
      return pending_chars.size();
   endfunction

   function void push_char(logic [7:0] code, logic last, logic ok);
      text_char_type rec;
      rec.code = code;
      rec.last = last;
      rec.ok   = ok;
      pending_chars.push_back(rec);
   endfunction

   // Expand one accepted request into its expected characters
   function void note_request(logic signed [63:0] value);
      bit [63:0] mag;
      bit [5:0]  digit_q[$];
      bit        neg;
      neg = value[63];
      // most negative value wraps to magnitude 2^63 in unsigned arithmetic
      mag = neg ? (64'd0 - value) : value;
      if (capacity < 8'd2) begin
         push_char(b62enc_pkg::CHAR_FAIL, 1'b1, 1'b0);
         return;
      end
      if (mag == 64'd0) begin
         push_char(b62enc_pkg::CHAR_ZERO, 1'b1, 1'b1);
         return;
      end
      // digits collected most significant first
      while (mag != 64'd0) begin
         digit_q.push_front(6'(mag % 64'd62));
         mag = mag / 64'd62;
      end
      if (digit_q.size() + int'(neg) + 1 > int'(capacity)) begin
         push_char(b62enc_pkg::CHAR_FAIL, 1'b1, 1'b0);
         return;
      end
      if (neg) begin
         push_char(b62enc_pkg::CHAR_MINUS, 1'b0, 1'b1);
      end
      foreach (digit_q[i]) begin
         push_char(alphabet[digit_q[i]], i == digit_q.size() - 1, 1'b1);
      end
   endfunction

   // Compare one emitted character with the oldest expectation
   function void check_char(logic [7:0] code, logic last, logic ok);
      text_char_type want;
      if (pending_chars.size() == 0) begin
         $display("%0t: unexpected character: code=%h last=%b ok=%b", $time, code, last, ok);
         errors++;
         return;
      end
      want = pending_chars.pop_front();
      if (want.code !== code) begin
         $display("%0t: char_code mismatch: expected %h, actual %h", $time, want.code, code);
         errors++;
      end
      if (want.last !== last) begin
         $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last);
         errors++;
      end
      if (want.ok !== ok) begin
         $display("%0t: ok mismatch: expected %b, actual %b", $time, want.ok, ok);
         errors++;
      end
   endfunction
endclass

module testbench;

   localparam logic [b62enc_pkg::CSR_ADDR_W-1:0] CAP_ADDR =
      b62enc_pkg::CSR_ADDR_W'(4 * int'(b62enc_pkg::REG_OUT_CAPACITY));
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 110;
   localparam int PHASE_ITEMS = 50;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic signed [b62enc_pkg::VALUE_W-1:0] req_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic [b62enc_pkg::CHAR_W-1:0]         rsp_char_code;
   logic                                  rsp_last;
   logic                                  rsp_ok;
   logic                                  csr_psel = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite = 1'b0;
   logic [b62enc_pkg::CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [b62enc_pkg::CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [b62enc_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                  csr_pready;

   encoding_scoreboard sb = new();
   bit idle_enable = 1'b1;
   int stall_left = 0;
   int quiet_cycles = 0;

   base62_signed_encoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_char_code(rsp_char_code),
      .rsp_last(rsp_last), .rsp_ok(rsp_ok),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // Receiver back-pressure in short bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Output monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_char(rsp_char_code, rsp_last, rsp_ok);
      end
   end

   // Watchdog: ends the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // One request; holds valid until accepted, with optional idle burst first
   task automatic send_value(input logic signed [b62enc_pkg::VALUE_W-1:0] value);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      sb.note_request(value);
   endtask

   // Stop sending and wait for every expected character
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   // Write out_capacity, then read it back
   task automatic write_capacity(input logic [b62enc_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.capacity = data[b62enc_pkg::CAP_W-1:0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[b62enc_pkg::CAP_W-1:0] !== data[b62enc_pkg::CAP_W-1:0]) begin
         $display("%0t: out_capacity readback mismatch: expected %h, actual %h",
                  $time, data[b62enc_pkg::CAP_W-1:0], csr_prdata[b62enc_pkg::CAP_W-1:0]);
         sb.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Mix of powers of 62 and the values just below them, extremes, and random magnitudes
   function automatic logic signed [b62enc_pkg::VALUE_W-1:0] random_value();
      logic [b62enc_pkg::VALUE_W-1:0] raw;
      logic [b62enc_pkg::VALUE_W-1:0] power;
      int                             pick;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         power = 64'd1;
         repeat ($urandom_range(0, 10)) power = power * 64'd62;
         raw = power - 64'($urandom_range(0, 1));
         if ($urandom_range(0, 1) == 1) raw = 64'd0 - raw;
      end else if (pick == 1) begin
         case ($urandom_range(0, 3))
            0: raw = 64'h8000_0000_0000_0000;
            1: raw = 64'h7FFF_FFFF_FFFF_FFFF;
            2: raw = 64'd0;
            default: raw = '1;
         endcase
      end else begin
         raw = raw >> $urandom_range(0, 63);
         if ($urandom_range(0, 1) == 1) raw = 64'd0 - raw;
      end
      return raw;
   endfunction

   initial begin
      logic signed [b62enc_pkg::VALUE_W-1:0] at_reset_cap[$];
      logic [b62enc_pkg::CAP_W-1:0]          phase_caps[$];

      at_reset_cap = '{64'sd0, 64'sd1, -64'sd1, 64'sd9, 64'sd10, 64'sd35, 64'sd36,
                       64'sd61, 64'sd62, -64'sd62, 64'sd3843, 64'sd238327,
                       64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                       64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset capacity of 13, most negative value just fits
      foreach (at_reset_cap[i]) send_value(at_reset_cap[i]);
      wait_drained();

      // Capacity below two fails every value, zero too
      write_capacity({24'hFFFFFF, 8'd0});
      send_value(64'sd0);
      send_value(-64'sd1);
      wait_drained();
      write_capacity(32'd1);
      send_value(64'sd0);
      wait_drained();

      // Capacity two: a single digit fits, a sign or a second digit does not
      write_capacity(32'd2);
      send_value(64'sd0);
      send_value(64'sd5);
      send_value(-64'sd5);
      send_value(64'sd62);
      wait_drained();

      // Capacity twelve: eleven digits fit only without sign
      write_capacity(32'd12);
      send_value(64'h8000_0000_0000_0000);
      send_value(64'h7FFF_FFFF_FFFF_FFFF);
      wait_drained();

      // Random phases, each under its own capacity; the sender drains in between
      phase_caps = '{8'd255, 8'd7, 8'd1, 8'd12, 8'($urandom_range(0, 255)), 8'd3,
                     8'($urandom_range(2, 14)), 8'd13};
      foreach (phase_caps[p]) begin
         write_capacity({24'($urandom), phase_caps[p]});
         idle_enable = (p != 3) && (p != phase_caps.size() - 1);
         repeat (PHASE_ITEMS) send_value(random_value());
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// File: files.f
design/b62enc_pkg.sv
design/b62enc_front.sv
design/b62enc_queue.sv
design/b62enc_back.sv
design/base62_signed_encoder.sv
tb/testbench.sv
